@@ hdl/fmf_pkg.sv @@
// ----------------------------------------------------------------------------
// fmf_pkg
// shared constants, types and helpers of the fourier multipole fit core
// ----------------------------------------------------------------------------
package fmf_pkg;

  localparam int DEF_MAX_SAMPLES = 64;
  localparam int DEF_MAX_ORDER   = 31;
  localparam int DEF_PHASE_BITS  = 16;

  // sine polynomial constants, unsigned q1.31
  localparam logic [31:0] SIN_A = 32'd3373259426;
  localparam logic [31:0] SIN_B = 32'd1377809732;
  localparam logic [31:0] SIN_C = 32'd152033954;

  // register indexes
  localparam logic REG_MAX_ORDER   = 1'b0;
  localparam logic REG_OUTPUT_MODE = 1'b1;

  // result kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_LOAD, ST_PHASE, ST_X2, ST_T1, ST_T2, ST_SIN,
    ST_PROD, ST_ACC, ST_DIVS, ST_DIVW, ST_STORE, ST_EMIT
  } fmf_state_t;

  // saturate a sign and magnitude pair to int32
  function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] q);
    logic [63:0] nq;
    nq = -q;
    if (!neg) begin
      sat_mag = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end else begin
      sat_mag = (q > 64'h8000_0000) ? 32'h8000_0000 : nq[31:0];
    end
  endfunction

  // saturate a signed 64-bit value to int32
  function automatic logic [31:0] sat64(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) begin
      sat64 = 32'h7FFF_FFFF;
    end else if (v < -64'sh8000_0000) begin
      sat64 = 32'h8000_0000;
    end else begin
      sat64 = v[31:0];
    end
  endfunction

endpackage

@@ hdl/fourier_multipole_fit_core.sv @@
// ----------------------------------------------------------------------------
// fourier_multipole_fit_core
// fourier series coefficients and reconstruction of a sampled set, q16.16
// ----------------------------------------------------------------------------
// usage
//   input channel: one beat per sample (value, angle, last_sample); samples
//   load one per cycle while in_stall is low. the beat with last_sample set
//   closes the set and starts the fit; in_stall stays high from then until
//   the last result of the run has entered the output register
//   output channel: one beat per order (coefficient mode) or per sample
//   (reconstruction mode), last_result on the final beat
//   apb port: max_order at 0x0, output_mode at 0x4, write only when idle
//   a run covers n samples and k = min(max_order, MAX_ORDER) + 1 orders:
//   each (sample, order) term takes its sine and its cosine through the
//   shared sine unit and multiplier; each order adds two divisions and a
//   store, plus the beat in coefficient mode; reconstruction then runs
//   all k orders again for each sample, plus its beat
//   reset empties the sample store and job queue and loads the register
//   defaults; a stalled receiver holds the output register and the engine
//   waits on it before the next beat
// ----------------------------------------------------------------------------
module fourier_multipole_fit_core #(
  parameter int MAX_SAMPLES = fmf_pkg::DEF_MAX_SAMPLES,
  parameter int MAX_ORDER   = fmf_pkg::DEF_MAX_ORDER,
  parameter int PHASE_BITS  = fmf_pkg::DEF_PHASE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  // sample channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] sample_value,
  input  logic [15:0]        sample_angle,
  input  logic               last_sample,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               result_kind,
  output logic [5:0]         result_index,
  output logic signed [31:0] primary_value,
  output logic signed [31:0] cosine_coefficient,
  output logic               last_result,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import fmf_pkg::*;

  localparam int NW  = $clog2(MAX_SAMPLES + 1);
  localparam int SAW = $clog2(MAX_SAMPLES);

  logic [4:0]            max_order;
  logic                  output_mode;
  logic                  reg_idx;

  logic                  job_push;
  logic [NW-1:0]         job_count;
  logic                  job_pop;
  logic                  job_valid;
  logic [NW-1:0]         job_head;
  logic                  run_done;
  logic [SAW-1:0]        rd_addr;
  logic signed [31:0]    rd_value;
  logic [PHASE_BITS-1:0] rd_angle;

  // register file, word addressed
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_order   <= 5'd4;
      output_mode <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_MAX_ORDER:   max_order   <= pwdata[4:0];
        REG_OUTPUT_MODE: output_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_ORDER:   prdata = {27'd0, max_order};
      REG_OUTPUT_MODE: prdata = {31'd0, output_mode};
      default:         prdata = '0;
    endcase
  end

  // front end: sample store and job posting
  fmf_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .PHASE_BITS  (PHASE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_value (sample_value),
    .sample_angle (sample_angle),
    .last_sample  (last_sample),
    .job_push     (job_push),
    .job_count    (job_count),
    .run_done     (run_done),
    .rd_addr      (rd_addr),
    .rd_value     (rd_value),
    .rd_angle     (rd_angle)
  );

  // job queue carries the sample count of each closed set
  fmf_queue #(.WIDTH(NW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_data  (job_count),
    .pop        (job_pop),
    .head_valid (job_valid),
    .head_data  (job_head)
  );

  // fit engine and output register
  fmf_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_ORDER   (MAX_ORDER),
    .PHASE_BITS  (PHASE_BITS)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .max_order          (max_order),
    .output_mode        (output_mode),
    .job_valid          (job_valid),
    .job_count          (job_head),
    .job_pop            (job_pop),
    .run_done           (run_done),
    .rd_addr            (rd_addr),
    .rd_value           (rd_value),
    .rd_angle           (rd_angle),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .result_kind        (result_kind),
    .result_index       (result_index),
    .primary_value      (primary_value),
    .cosine_coefficient (cosine_coefficient),
    .last_result        (last_result)
  );
endmodule

@@ hdl/fmf_queue.sv @@
// ----------------------------------------------------------------------------
// fmf_queue
// two-entry job queue between the sample front end and the fit engine
// ----------------------------------------------------------------------------
module fmf_queue #(
  parameter int WIDTH = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);
  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign head_valid = (fill != 2'd0);
  assign head_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && head_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop && head_valid);
    end
  end
endmodule

@@ hdl/fmf_front.sv @@
// ----------------------------------------------------------------------------
// fmf_front
// accepts sample beats, fills the sample store and posts a job on the last one
// ----------------------------------------------------------------------------
module fmf_front #(
  parameter int MAX_SAMPLES = 64,
  parameter int PHASE_BITS  = 16,
  localparam int NW  = $clog2(MAX_SAMPLES + 1),
  localparam int SAW = $clog2(MAX_SAMPLES)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [31:0]     sample_value,
  input  logic [15:0]            sample_angle,
  input  logic                   last_sample,
  output logic                   job_push,
  output logic [NW-1:0]          job_count,
  input  logic                   run_done,
  input  logic [SAW-1:0]         rd_addr,
  output logic signed [31:0]     rd_value,
  output logic [PHASE_BITS-1:0]  rd_angle
);
  logic signed [31:0]        value_mem [MAX_SAMPLES];
  logic [PHASE_BITS-1:0]     angle_mem [MAX_SAMPLES];
  logic [NW-1:0]             count;
  logic [NW-1:0]             count_next;
  logic                      busy;
  logic                      accept;
  logic                      has_room;
  logic [PHASE_BITS+15:0]    angle_ext;

  assign in_stall   = busy;
  assign accept     = in_valid && !busy;
  assign has_room   = (count < NW'(MAX_SAMPLES));
  assign count_next = has_room ? count + NW'(1) : count;
  assign angle_ext  = {{PHASE_BITS{1'b0}}, sample_angle};
  assign job_push   = accept && last_sample;
  assign job_count  = count_next;

  always_ff @(posedge clk) begin
    if (accept && has_room) begin
      value_mem[count[SAW-1:0]] <= sample_value;
      angle_mem[count[SAW-1:0]] <= angle_ext[PHASE_BITS-1:0];
    end
    rd_value <= value_mem[rd_addr];
    rd_angle <= angle_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b0;
    end else begin
      if (accept) begin
        count <= last_sample ? '0 : count_next;
      end
      if (job_push) begin
        busy <= 1'b1;
      end else if (run_done) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

@@ hdl/fmf_div.sv @@
// ----------------------------------------------------------------------------
// fmf_div
// restoring divider, one quotient bit per cycle over a 64-bit dividend
// ----------------------------------------------------------------------------
module fmf_div #(
  parameter int DW = 22
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [63:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [63:0]   quot
);
  logic [DW:0]   rem;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_n;
  logic          ge;
  logic [5:0]    cnt;
  logic          busy;

  assign rem_sh = {rem[DW-1:0], quot[63]};
  assign ge     = (rem_sh >= {1'b0, divisor});
  assign rem_n  = ge ? rem_sh - {1'b0, divisor} : rem_sh;

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
    end else if (busy) begin
      rem  <= rem_n;
      quot <= {quot[62:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == 6'd63);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule

@@ hdl/fmf_back.sv @@
// ----------------------------------------------------------------------------
// fmf_back
// fit engine: sine/cosine multiply-accumulate, scaling, reconstruction, output
// ----------------------------------------------------------------------------
module fmf_back #(
  parameter int MAX_SAMPLES = 64,
  parameter int MAX_ORDER   = 31,
  parameter int PHASE_BITS  = 16,
  localparam int NW  = $clog2(MAX_SAMPLES + 1),
  localparam int SAW = $clog2(MAX_SAMPLES),
  localparam int OW  = $clog2(MAX_ORDER + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [4:0]            max_order,
  input  logic                  output_mode,
  input  logic                  job_valid,
  input  logic [NW-1:0]         job_count,
  output logic                  job_pop,
  output logic                  run_done,
  output logic [SAW-1:0]        rd_addr,
  input  logic signed [31:0]    rd_value,
  input  logic [PHASE_BITS-1:0] rd_angle,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  result_kind,
  output logic [5:0]            result_index,
  output logic signed [31:0]    primary_value,
  output logic signed [31:0]    cosine_coefficient,
  output logic                  last_result
);
  import fmf_pkg::*;

  localparam int DW = NW + 15;
  localparam int QW = PHASE_BITS - 2;

  fmf_state_t state, state_next;

  logic signed [31:0] sin_mem [MAX_ORDER + 1];
  logic signed [31:0] cos_mem [MAX_ORDER + 1];
  logic signed [31:0] sin_rd;
  logic signed [31:0] cos_rd;

  logic [NW-1:0]          n;
  logic [OW-1:0]          top;
  logic [OW-1:0]          top_c;
  logic                   mode;
  logic                   pass;
  logic [OW-1:0]          m;
  logic [SAW-1:0]         i;
  logic [PHASE_BITS-1:0]  ang;
  logic signed [31:0]     opa;
  logic signed [31:0]     opb;
  logic                   kcos;
  logic [16:0]            xr;
  logic [1:0]             quad;
  logic [16:0]            x2;
  logic [31:0]            t;
  logic signed [31:0]     s;
  logic signed [63:0]     prod;
  logic signed [63:0]     tsin;
  logic signed [63:0]     acc_a;
  logic signed [63:0]     acc_b;
  logic                   dsel;
  logic [31:0]            res_a;
  logic [31:0]            res_b;

  logic                   last_i;
  logic                   last_m;
  logic                   out_free;
  logic                   div_start;
  logic                   div_done;
  logic [63:0]            div_quot;
  logic signed [63:0]     div_src;
  logic [63:0]            div_mag;
  logic [63:0]            dividend;
  logic [DW-1:0]          divisor;

  // phase and folded fraction
  logic [OW+PHASE_BITS-1:0] mprod;
  logic [PHASE_BITS-1:0]    ph;
  logic [QW+15:0]           fx;
  logic [16:0]              xq;
  logic [32:0]              sq;
  logic [44:0]              ct;
  logic [47:0]              bt;
  logic [48:0]              at;
  logic [31:0]              smag;
  logic signed [63:0]       full;
  logic signed [63:0]       term;
  logic signed [63:0]       rsum;

  assign top_c  = (int'(max_order) > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(max_order);
  assign last_i = (NW'(i) == n - NW'(1));
  assign last_m = (m == top);
  assign out_free = !out_valid || !out_stall;
  assign rd_addr  = i;

  assign mprod = (OW+PHASE_BITS)'(m) * (OW+PHASE_BITS)'(ang);
  assign ph    = mprod[PHASE_BITS-1:0] +
                 (kcos ? (PHASE_BITS'(1) << QW) : PHASE_BITS'(0));
  assign fx    = {ph[QW-1:0], 16'd0} >> QW;
  assign xq    = ph[QW] ? 17'd65536 - {1'b0, fx[15:0]} : {1'b0, fx[15:0]};
  assign sq    = 33'(xr) * 33'(xr);
  assign ct    = 45'(SIN_C) * 45'(x2);
  assign bt    = 48'(SIN_B - t) * 48'(x2);
  assign at    = 49'(SIN_A - t) * 49'(xr);
  assign smag  = at[48:17];
  assign full  = (kcos ? opb : opa) * s;
  assign term  = (m == '0) ? (tsin + prod) >>> 1 : tsin + prod;
  assign rsum  = (acc_a + 64'sd32768) >>> 16;

  assign div_src  = dsel ? acc_b : acc_a;
  assign div_mag  = div_src[63] ? -div_src : div_src;
  assign divisor  = DW'(n) << 15;
  assign dividend = div_mag + (64'(n) << 14);

  // coefficient store, registered read at the current order
  always_ff @(posedge clk) begin
    if (state == ST_STORE) begin
      sin_mem[m] <= res_a;
      cos_mem[m] <= res_b;
    end
    sin_rd <= sin_mem[m];
    cos_rd <= cos_mem[m];
  end

  fmf_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    div_start  = 1'b0;
    run_done   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ:  state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_PHASE;
      ST_PHASE: state_next = ST_X2;
      ST_X2:    state_next = ST_T1;
      ST_T1:    state_next = ST_T2;
      ST_T2:    state_next = ST_SIN;
      ST_SIN:   state_next = ST_PROD;
      ST_PROD:  state_next = ST_ACC;
      ST_ACC: begin
        if (!kcos) begin
          state_next = ST_PHASE;
        end else if (!pass) begin
          state_next = last_i ? ST_DIVS : ST_READ;
        end else begin
          state_next = last_m ? ST_EMIT : ST_READ;
        end
      end
      ST_DIVS: begin
        div_start  = 1'b1;
        state_next = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          state_next = dsel ? ST_STORE : ST_DIVS;
        end
      end
      ST_STORE: state_next = mode ? ST_EMIT : ST_READ;
      ST_EMIT: begin
        if (out_free) begin
          if ((!pass && last_m) || (pass && last_i)) begin
            run_done   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        n     <= job_count;
        top   <= top_c;
        mode  <= output_mode;
        pass  <= 1'b0;
        m     <= '0;
        i     <= '0;
        acc_a <= '0;
        acc_b <= '0;
        dsel  <= 1'b0;
      end
      ST_LOAD: begin
        ang  <= rd_angle;
        opa  <= pass ? sin_rd : rd_value;
        opb  <= pass ? cos_rd : rd_value;
        kcos <= 1'b0;
      end
      ST_PHASE: begin
        xr   <= xq;
        quad <= ph[PHASE_BITS-1:PHASE_BITS-2];
      end
      ST_X2:   x2 <= sq[32:16];
      ST_T1:   t  <= 32'(ct >> 16);
      ST_T2:   t  <= bt[47:16];
      ST_SIN:  s  <= quad[1] ? -$signed(smag) : $signed(smag);
      ST_PROD: prod <= full >>> 14;
      ST_ACC: begin
        if (!kcos) begin
          tsin <= prod;
          kcos <= 1'b1;
        end else if (!pass) begin
          acc_a <= acc_a + tsin;
          acc_b <= acc_b + prod;
          dsel  <= 1'b0;
          if (!last_i) begin
            i <= i + SAW'(1);
          end
        end else begin
          acc_a <= acc_a + term;
          if (!last_m) begin
            m <= m + OW'(1);
          end
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          if (dsel) begin
            res_b <= sat_mag(div_src[63], div_quot);
          end else begin
            res_a <= sat_mag(div_src[63], div_quot);
          end
          dsel <= ~dsel;
        end
      end
      ST_STORE: begin
        if (!mode) begin
          i     <= '0;
          acc_a <= '0;
          acc_b <= '0;
          if (last_m) begin
            pass <= 1'b1;
            m    <= '0;
          end else begin
            m <= m + OW'(1);
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          acc_a <= '0;
          acc_b <= '0;
          if (!pass) begin
            m <= m + OW'(1);
            i <= '0;
          end else begin
            i <= i + SAW'(1);
            m <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      if (!pass) begin
        result_kind        <= KIND_COEF;
        result_index       <= 6'(m);
        primary_value      <= res_a;
        cosine_coefficient <= res_b;
        last_result        <= last_m;
      end else begin
        result_kind        <= KIND_SAMPLE;
        result_index       <= 6'(i);
        primary_value      <= sat64(rsum);
        cosine_coefficient <= '0;
        last_result        <= last_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end
endmodule
